// ===== rtl/core/tga_rle_pixel_decoder_defines.svh =====
// Assertion macros for the checker file of the Targa pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TGA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tga_pkg.sv =====
// Types, register indexes, pixel size codes and the 5-bit scaling table.
package tga_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_MODE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_PRESENT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_TOTAL     = 2'd3;

   localparam logic [2:0] BPP_GRAY = 3'd1;
   localparam logic [2:0] BPP_555  = 3'd2;
   localparam logic [2:0] BPP_BGR  = 3'd3;
   localparam logic [2:0] BPP_BGRA = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   // v * 255 / 31, truncated, for every 5-bit channel value.
   localparam logic [7:0] SCALE5_TABLE [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   function automatic logic [7:0] scale5(input logic [4:0] v);
      return SCALE5_TABLE[v];
   endfunction

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// A result word is registered: it is on rsp_* in the cycle after the byte that completes it is accepted.
// One byte per cycle while req_tready is high; the per-byte state update (packet header check and the
// 32-bit pixel counter add and compare) is combinational.
// A single output register parts the two sides, so req_tready stays high while it drains.
// Reset is synchronous and active high: it clears the decode state, empties the output
// register and returns the configuration registers to their defaults.
module tga_rle_pixel_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // data_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [39:0]                      rsp_tdata,   // red, green, blue, alpha, repeat_count
   output logic                             rsp_tuser,   // overrun_error
   output logic                             rsp_tlast,   // image_complete
   input  logic                             csr_we,
   input  logic [tga_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tga_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic        rle_mode_ff;
   logic [2:0]  bpp_ff;
   logic        alpha_present_ff;
   logic [31:0] pixel_total_ff;

   // Decode state.
   logic        awaiting_header_ff;
   logic        packet_is_run_ff;
   logic [7:0]  packet_left_ff;
   logic [1:0]  byte_pos_ff;
   logic [23:0] held_ff;
   logic [31:0] pixels_written_ff;
   logic        stopped_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic        rsp_error_ff;
   logic        rsp_last_ff;

   logic        req_fire;
   logic [2:0]  bpp_eff;
   logic        ignore_byte;
   logic        is_header;
   logic [7:0]  hdr_count;
   logic [31:0] pixels_remaining;
   logic        overrun;
   logic [2:0]  pos_inc;
   logic        gather;
   logic [23:0] held_in;
   logic [31:0] pixel_bytes;
   logic [7:0]  count;
   logic [7:0]  packet_left_dec;
   logic [31:0] pixels_written_in;
   logic        complete;
   logic        has_result;
   tga_pkg::rgba_type rgba;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (bpp_ff == 3'd0) begin
         bpp_eff = tga_pkg::BPP_GRAY;
      end else if (bpp_ff > tga_pkg::BPP_BGRA) begin
         bpp_eff = tga_pkg::BPP_BGRA;
      end else begin
         bpp_eff = bpp_ff;
      end
   end

   assign ignore_byte      = stopped_ff || (pixels_written_ff >= pixel_total_ff);
   assign is_header        = rle_mode_ff && awaiting_header_ff;
   assign hdr_count        = {1'b0, req_tdata[6:0]} + 8'd1;
   // Only used while pixels_written is below the total, so this never wraps.
   assign pixels_remaining = pixel_total_ff - pixels_written_ff;
   assign overrun          = {24'd0, hdr_count} > pixels_remaining;

   assign pos_inc = {1'b0, byte_pos_ff} + 3'd1;
   assign gather  = pos_inc < bpp_eff;

   always_comb begin
      held_in = held_ff;
      case (byte_pos_ff)
         2'd0:    held_in[7:0]   = held_ff[7:0]   | req_tdata;
         2'd1:    held_in[15:8]  = held_ff[15:8]  | req_tdata;
         2'd2:    held_in[23:16] = held_ff[23:16] | req_tdata;
         default: held_in        = held_ff;
      endcase
   end

   // The byte that completes a pixel lands at the current position; later bytes read zero.
   always_comb begin
      pixel_bytes = 32'd0;
      case (byte_pos_ff)
         2'd0:    pixel_bytes = {24'd0, req_tdata};
         2'd1:    pixel_bytes = {16'd0, req_tdata, held_ff[7:0]};
         2'd2:    pixel_bytes = {8'd0, req_tdata, held_ff[15:0]};
         default: pixel_bytes = {req_tdata, held_ff};
      endcase
   end

   tga_pix_unpack u_unpack (
      .pixel_bytes   (pixel_bytes),
      .bpp           (bpp_eff),
      .alpha_present (alpha_present_ff),
      .rgba          (rgba)
   );

   assign packet_left_dec = packet_left_ff - 8'd1;

   always_comb begin
      if (rle_mode_ff && packet_is_run_ff) begin
         count = packet_left_ff;
      end else begin
         count = 8'd1;
      end
   end

   assign pixels_written_in = pixels_written_ff + {24'd0, count};
   assign complete          = pixels_written_in >= pixel_total_ff;
   assign has_result        = !ignore_byte && (is_header ? overrun : !gather);

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_mode_ff      <= 1'b0;
         bpp_ff           <= tga_pkg::BPP_BGR;
         alpha_present_ff <= 1'b0;
         pixel_total_ff   <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            tga_pkg::CSR_RLE_MODE:        rle_mode_ff      <= csr_wdata[0];
            tga_pkg::CSR_BYTES_PER_PIXEL: bpp_ff           <= csr_wdata[2:0];
            tga_pkg::CSR_ALPHA_PRESENT:   alpha_present_ff <= csr_wdata[0];
            tga_pkg::CSR_PIXEL_TOTAL:     pixel_total_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_header_ff <= 1'b1;
         packet_is_run_ff   <= 1'b0;
         packet_left_ff     <= 8'd0;
         byte_pos_ff        <= 2'd0;
         held_ff            <= 24'd0;
         pixels_written_ff  <= 32'd0;
         stopped_ff         <= 1'b0;
      end else if (req_fire && !ignore_byte) begin
         if (is_header) begin
            if (overrun) begin
               stopped_ff <= 1'b1;
            end else begin
               packet_is_run_ff   <= req_tdata[7];
               packet_left_ff     <= hdr_count;
               awaiting_header_ff <= 1'b0;
               byte_pos_ff        <= 2'd0;
               held_ff            <= 24'd0;
            end
         end else if (gather) begin
            held_ff     <= held_in;
            byte_pos_ff <= pos_inc[1:0];
         end else begin
            held_ff           <= 24'd0;
            byte_pos_ff       <= 2'd0;
            pixels_written_ff <= pixels_written_in;
            if (rle_mode_ff) begin
               if (packet_is_run_ff) begin
                  packet_left_ff     <= 8'd0;
                  awaiting_header_ff <= 1'b1;
               end else begin
                  packet_left_ff <= packet_left_dec;
                  if (packet_left_dec == 8'd0) begin
                     awaiting_header_ff <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= has_result;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         if (is_header) begin
            rsp_data_ff  <= 40'd0;
            rsp_error_ff <= 1'b1;
            rsp_last_ff  <= 1'b0;
         end else begin
            rsp_data_ff  <= {count, rgba.alpha, rgba.blue, rgba.green, rgba.red};
            rsp_error_ff <= 1'b0;
            rsp_last_ff  <= complete;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_error_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/tga_pix_unpack.sv =====
// Expands one gathered pixel of 1 to 4 bytes into 8-bit RGBA.
module tga_pix_unpack (
   input  logic [31:0]           pixel_bytes,   // byte 0 in the lowest bits
   input  logic [2:0]            bpp,           // already limited to 1..4
   input  logic                  alpha_present,
   output tga_pkg::rgba_type     rgba
);

   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;
   logic [7:0] b3;

   assign b0 = pixel_bytes[7:0];
   assign b1 = pixel_bytes[15:8];
   assign b2 = pixel_bytes[23:16];
   assign b3 = pixel_bytes[31:24];

   always_comb begin
      rgba.alpha = tga_pkg::ALPHA_OPAQUE;
      case (bpp)
         tga_pkg::BPP_GRAY: begin
            rgba.red   = b0;
            rgba.green = b0;
            rgba.blue  = b0;
            if (alpha_present) begin
               rgba.alpha = b0;
            end
         end
         tga_pkg::BPP_555: begin
            // Little-endian word: blue in bits 4..0, green 9..5, red 14..10.
            rgba.blue  = tga_pkg::scale5(b0[4:0]);
            rgba.green = tga_pkg::scale5({b1[1:0], b0[7:5]});
            rgba.red   = tga_pkg::scale5(b1[6:2]);
            if (alpha_present) begin
               rgba.alpha = b1[7] ? 8'd0 : tga_pkg::ALPHA_OPAQUE;
            end
         end
         default: begin
            rgba.blue  = b0;
            rgba.green = b1;
            rgba.red   = b2;
            if (alpha_present && (bpp == tga_pkg::BPP_BGRA)) begin
               rgba.alpha = b3;
            end
         end
      endcase
   end

endmodule

// ===== rtl/core/tga_rle_checker.sv =====
// Port-level checker for the Targa pixel decoder and its bind to the top level.
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result word keeps its contents.
   `TGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result word changed while stalled")

   // An empty output register never holds back the input.
   `TGA_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "input stalled with empty output register")

   // The overrun word carries no pixel and does not close the image.
   `TGA_ASSERT_NOW(a_error_word_clear, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata == 40'd0) && !rsp_tlast, "overrun word carries pixel data")

   // Once the overrun word has gone out, the decoder stays silent.
   `TGA_ASSERT_NEXT(a_silent_after_error, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser, !rsp_tvalid, "result word after overrun")

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (.*);
